FILE: rtl/multi_session_timer_manager_defines.svh
// Assertion macros for the session timer manager checker
`ifndef MULTI_SESSION_TIMER_MANAGER_DEFINES_SVH
`define MULTI_SESSION_TIMER_MANAGER_DEFINES_SVH

// Same-cycle implication, reset masks the check
`define MSTM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check
`define MSTM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mstm_pkg.sv
// Types, constants and helpers shared by the session timer manager
`timescale 1ns / 1ps

package mstm_pkg;

  localparam int NUM_SESSIONS_DEF = 16;
  localparam int NUM_TIMERS       = 10;
  localparam int TW               = 32;
  localparam int RW               = 31;
  localparam int CMD_W            = 2;
  localparam int SESSION_W        = 4;
  localparam int TID_W            = 4;
  localparam int CFG_IDX_W        = 2;

  localparam logic [RW-1:0] EMPTY_WAKE_RESET = RW'(10000);

  localparam logic [TID_W-1:0] TMR_ACK   = TID_W'(0);
  localparam logic [TID_W-1:0] TMR_IDLE  = TID_W'(7);
  localparam logic [TID_W-1:0] TMR_RETRY = TID_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_IDLE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RETRY = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY = CFG_IDX_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ST_RD,
    ST_ST_CMP,
    ST_RM_SCAN,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_DO,
    ST_SR_SCAN,
    ST_SR_RD,
    ST_SR_CHK,
    ST_SV_RD,
    ST_SV_CHK,
    ST_SV_UPD,
    ST_EA_RD,
    ST_EA_CHK,
    ST_WK_RD,
    ST_WK_USE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic          sub;
    logic [TW-1:0] a;
    logic [TW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [TW-1:0] res;
    logic          earlier;
    logic          sleeping;
  } alu_res_t;

  // visiting order when the earliest deadline is rebuilt
  function automatic logic [TID_W-1:0] scan_timer(logic [TID_W-1:0] k);
    logic [TID_W-1:0] t;
    case (k)
      4'd0:    t = 4'd8;
      4'd1:    t = 4'd0;
      4'd2:    t = 4'd1;
      4'd3:    t = 4'd7;
      4'd4:    t = 4'd3;
      4'd5:    t = 4'd4;
      4'd6:    t = 4'd2;
      4'd7:    t = 4'd9;
      4'd8:    t = 4'd5;
      4'd9:    t = 4'd6;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/mstm_ifc.sv
// Valid/ready channel interfaces for commands and results
`timescale 1ns / 1ps

interface mstm_cmd_if import mstm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [SESSION_W-1:0] session;
  logic [TID_W-1:0]     timer_id;
  logic [RW-1:0]        delta_ticks;
  logic [TW-1:0]        now_time;

  modport source (output valid, command, session, timer_id, delta_ticks, now_time,
                  input ready);
  modport sink   (input valid, command, session, timer_id, delta_ticks, now_time,
                  output ready);
endinterface

interface mstm_res_if import mstm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic                  session_valid;
  logic [SESSION_W-1:0]  out_session;
  logic [NUM_TIMERS-1:0] expired_mask;
  logic                  poll_cycle;
  logic [TW-1:0]         next_wakeup;
  logic                  last;

  modport source (output valid, session_valid, out_session, expired_mask, poll_cycle,
                  next_wakeup, last, input ready);
  modport sink   (input valid, session_valid, out_session, expired_mask, poll_cycle,
                  next_wakeup, last, output ready);
endinterface

FILE: rtl/mstm_ram.sv
// Generic simple dual-port RAM, registered read
`timescale 1ns / 1ps

module mstm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mstm_alu.sv
// Shared add/subtract unit with wraparound time compares
`timescale 1ns / 1ps

module mstm_alu import mstm_pkg::*; (
  input  alu_req_t req,
  output alu_res_t rsp
);

  logic [TW-1:0] sum;

  assign sum          = req.a + (req.sub ? ~req.b : req.b) + TW'(req.sub);
  assign rsp.res      = sum;
  assign rsp.earlier  = sum[TW-1];
  assign rsp.sleeping = (sum != '0) && !sum[TW-1];

endmodule

FILE: rtl/multi_session_timer_manager.sv
// Deadline-ordered timer queue: per-session timers served by earliest deadline.
// Start: removal scan, then an insertion search through the queue.
// Tick: for each serviced session a timer pass and removal scan, then, while timers remain
// running, a rebuild of its earliest deadline and a re-insert.
// One command at a time; ready again once its final result is in the output register.
// Reset clears running marks, queue and registers; the deadline memories are not cleared.
`timescale 1ns / 1ps

module multi_session_timer_manager import mstm_pkg::*; #(
  parameter int NUM_SESSIONS = NUM_SESSIONS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  mstm_cmd_if.sink             cmd,
  mstm_res_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RW-1:0]        cfg_data
);

  localparam int SIW    = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
  localparam int CW     = $clog2(NUM_SESSIONS + 1);
  localparam int DDEPTH = NUM_SESSIONS * NUM_TIMERS;
  localparam int DAW    = $clog2(DDEPTH);

  state_t state, state_next;

  cmd_t             op;
  logic [SIW-1:0]   sess;
  logic [TID_W-1:0] tid;
  logic [RW-1:0]    delta;
  logic [TW-1:0]    now;

  logic [NUM_TIMERS-1:0] marks [NUM_SESSIONS];
  logic [NUM_SESSIONS-1:0] served;
  logic [SIW-1:0] q     [NUM_SESSIONS];
  logic [SIW-1:0] q_rm  [NUM_SESSIONS];
  logic [SIW-1:0] q_ins [NUM_SESSIONS];
  logic [CW-1:0]  qcount, idx;

  logic [TID_W-1:0]      tcnt;
  logic [NUM_TIMERS-1:0] m, mask;
  logic                  poll, first;
  logic [TW-1:0]         tval, key, cur, wake;

  logic                  pend_v, pend_poll;
  logic [SIW-1:0]        pend_sess;
  logic [NUM_TIMERS-1:0] pend_mask;
  logic                  e_valid, e_poll, e_last;
  logic [SIW-1:0]        e_sess;
  logic [NUM_TIMERS-1:0] e_mask;

  logic [RW-1:0] idle_ticks, retry_ticks, empty_ticks;

  logic           ed_we;
  logic [SIW-1:0] ed_waddr, ed_raddr;
  logic [TW-1:0]  ed_wdata, ed_rdata;
  logic           dl_we;
  logic [DAW-1:0] dl_waddr, dl_raddr;
  logic [TW-1:0]  dl_wdata, dl_rdata;

  alu_req_t alu_in;
  alu_res_t alu_out;

  logic             in_range;
  logic [SIW-1:0]   qi;
  logic             scan_end, tdone, m_bit, reload;
  logic [TID_W-1:0] st;
  logic [TW-1:0]    key_new;

  function automatic logic [DAW-1:0] dl_addr(logic [SIW-1:0] s, logic [TID_W-1:0] t);
    return DAW'(s) * DAW'(NUM_TIMERS) + DAW'(t);
  endfunction

  assign in_range = (32'(cmd.session) < 32'(NUM_SESSIONS)) &&
                    (32'(cmd.timer_id) < 32'(NUM_TIMERS));
  assign qi       = q[idx[SIW-1:0]];
  assign scan_end = (idx >= qcount);
  assign tdone    = (tcnt == TID_W'(NUM_TIMERS));
  assign m_bit    = tdone ? 1'b0 : m[tcnt];
  assign st       = scan_timer(tcnt);
  assign reload   = (tcnt == TMR_IDLE) || ((tcnt == TMR_RETRY) && (retry_ticks != '0));
  assign key_new  = ((marks[sess] == '0) || alu_out.earlier) ? tval : ed_rdata;

  // queue with one entry taken out or put in at idx
  always_comb begin
    for (int j = 0; j < NUM_SESSIONS; j++) begin
      if ((j < NUM_SESSIONS - 1) && (CW'(j) >= idx)) begin
        q_rm[j] = q[(j + 1 < NUM_SESSIONS) ? j + 1 : j];
      end else begin
        q_rm[j] = q[j];
      end
      if (CW'(j) < idx) begin
        q_ins[j] = q[j];
      end else if (CW'(j) == idx) begin
        q_ins[j] = sess;
      end else begin
        q_ins[j] = q[(j > 0) ? j - 1 : 0];
      end
    end
  end

  mstm_alu u_alu (
    .req (alu_in),
    .rsp (alu_out)
  );

  mstm_ram #(.WIDTH(TW), .DEPTH(NUM_SESSIONS)) u_ed_ram (
    .clk   (clk),
    .we    (ed_we),
    .waddr (ed_waddr),
    .wdata (ed_wdata),
    .raddr (ed_raddr),
    .rdata (ed_rdata)
  );

  mstm_ram #(.WIDTH(TW), .DEPTH(DDEPTH)) u_dl_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (dl_raddr),
    .rdata (dl_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          if (cmd_t'(cmd.command) == CMD_TICK) begin
            state_next = ST_SR_SCAN;
          end else if ((cmd_t'(cmd.command) == CMD_START) && in_range) begin
            state_next = ST_ST_RD;
          end else begin
            state_next = ST_WK_RD;
          end
        end
      end
      ST_ST_RD:  state_next = ST_ST_CMP;
      ST_ST_CMP: state_next = ST_RM_SCAN;
      ST_RM_SCAN: begin
        if (scan_end || (qi == sess)) begin
          if (op == CMD_START) begin
            state_next = ST_INS_RD;
          end else begin
            state_next = (m != '0) ? ST_EA_RD : ST_SR_SCAN;
          end
        end
      end
      ST_INS_RD:  state_next = scan_end ? ST_INS_DO : ST_INS_CMP;
      ST_INS_CMP: state_next = alu_out.earlier ? ST_INS_DO : ST_INS_RD;
      ST_INS_DO:  state_next = (op == CMD_START) ? ST_WK_RD : ST_SR_SCAN;
      ST_SR_SCAN: begin
        if (scan_end) begin
          state_next = ST_WK_RD;
        end else if (!served[qi]) begin
          state_next = ST_SR_RD;
        end
      end
      ST_SR_RD:  state_next = ST_SR_CHK;
      ST_SR_CHK: state_next = (alu_out.sleeping || pend_v) ? ST_WK_RD : ST_SV_RD;
      ST_SV_RD: begin
        if (tdone) begin
          state_next = ST_RM_SCAN;
        end else if (m_bit) begin
          state_next = ST_SV_CHK;
        end
      end
      ST_SV_CHK: state_next = (!alu_out.sleeping && reload) ? ST_SV_UPD : ST_SV_RD;
      ST_SV_UPD: state_next = ST_SV_RD;
      ST_EA_RD: begin
        if (tdone) begin
          state_next = ST_INS_RD;
        end else if (m[st]) begin
          state_next = ST_EA_CHK;
        end
      end
      ST_EA_CHK: state_next = ST_EA_RD;
      ST_WK_RD:  state_next = ST_WK_USE;
      ST_WK_USE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!res.valid || res.ready) begin
          state_next = e_last ? ST_IDLE : ST_SV_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory, unit and handshake controls
  always_comb begin
    cmd.ready = (state == ST_IDLE);
    ed_we     = 1'b0;
    ed_waddr  = sess;
    ed_wdata  = cur;
    ed_raddr  = sess;
    dl_we     = 1'b0;
    dl_waddr  = dl_addr(sess, tcnt);
    dl_wdata  = alu_out.res;
    dl_raddr  = dl_addr(sess, tcnt);
    alu_in    = '{sub: 1'b1, a: now, b: now};
    unique case (state)
      ST_ST_RD: begin
        alu_in = '{sub: 1'b0, a: now, b: {1'b0, delta}};
      end
      ST_ST_CMP: begin
        alu_in   = '{sub: 1'b1, a: tval, b: ed_rdata};
        ed_we    = 1'b1;
        ed_wdata = key_new;
        dl_we    = 1'b1;
        dl_waddr = dl_addr(sess, tid);
        dl_wdata = tval;
      end
      ST_INS_RD:  ed_raddr = qi;
      ST_INS_CMP: alu_in = '{sub: 1'b1, a: key, b: ed_rdata};
      ST_SR_CHK:  alu_in = '{sub: 1'b1, a: ed_rdata, b: now};
      ST_SV_CHK:  alu_in = '{sub: 1'b1, a: dl_rdata, b: now};
      ST_SV_UPD: begin
        alu_in = '{sub: 1'b0, a: now,
                   b: {1'b0, (tcnt == TMR_IDLE) ? idle_ticks : retry_ticks}};
        dl_we  = 1'b1;
      end
      ST_EA_RD: begin
        dl_raddr = dl_addr(sess, st);
        ed_we    = tdone;
      end
      ST_EA_CHK: alu_in = '{sub: 1'b1, a: dl_rdata, b: cur};
      ST_WK_RD:  ed_raddr = q[0];
      ST_WK_USE: alu_in = '{sub: 1'b0, a: now, b: {1'b0, empty_ticks}};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      qcount      <= '0;
      pend_v      <= 1'b0;
      res.valid   <= 1'b0;
      idle_ticks  <= '0;
      retry_ticks <= '0;
      empty_ticks <= EMPTY_WAKE_RESET;
      for (int i = 0; i < NUM_SESSIONS; i++) begin
        marks[i] <= '0;
      end
    end else begin
      state <= state_next;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_IDLE:  idle_ticks  <= cfg_data;
          REG_RETRY: retry_ticks <= cfg_data;
          REG_EMPTY: empty_ticks <= cfg_data;
          default: ;
        endcase
      end

      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd.valid) begin
            op        <= cmd_t'(cmd.command);
            sess      <= SIW'(cmd.session);
            tid       <= cmd.timer_id;
            delta     <= cmd.delta_ticks;
            now       <= cmd.now_time;
            served    <= '0;
            idx       <= '0;
            pend_v    <= 1'b0;
            pend_sess <= '0;
            pend_mask <= '0;
            pend_poll <= 1'b0;
            e_valid   <= 1'b0;
            e_sess    <= '0;
            e_mask    <= '0;
            e_poll    <= 1'b0;
            e_last    <= 1'b1;
            if ((cmd_t'(cmd.command) == CMD_STOP) && in_range) begin
              marks[SIW'(cmd.session)][cmd.timer_id] <= 1'b0;
            end
          end
        end
        ST_ST_RD: tval <= alu_out.res;
        ST_ST_CMP: begin
          key              <= key_new;
          marks[sess][tid] <= 1'b1;
          idx              <= '0;
        end
        ST_RM_SCAN: begin
          if (!scan_end && (qi != sess)) begin
            idx <= idx + CW'(1);
          end else begin
            if (!scan_end) begin
              q      <= q_rm;
              qcount <= qcount - CW'(1);
            end
            idx   <= '0;
            tcnt  <= '0;
            first <= 1'b1;
            // nothing left running: service ends here
            if ((op != CMD_START) && (m == '0)) begin
              pend_v    <= 1'b1;
              pend_sess <= sess;
              pend_mask <= mask;
              pend_poll <= poll;
            end
          end
        end
        ST_INS_CMP: begin
          if (!alu_out.earlier) begin
            idx <= idx + CW'(1);
          end
        end
        ST_INS_DO: begin
          q      <= q_ins;
          qcount <= qcount + CW'(1);
          if (op != CMD_START) begin
            pend_v    <= 1'b1;
            pend_sess <= sess;
            pend_mask <= mask;
            pend_poll <= poll;
            idx       <= '0;
          end
        end
        ST_SR_SCAN: begin
          if (scan_end) begin
            e_valid <= pend_v;
            e_sess  <= pend_sess;
            e_mask  <= pend_mask;
            e_poll  <= pend_poll;
            e_last  <= 1'b1;
          end else if (!served[qi]) begin
            sess <= qi;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_SR_CHK: begin
          if (alu_out.sleeping) begin
            e_valid <= pend_v;
            e_sess  <= pend_sess;
            e_mask  <= pend_mask;
            e_poll  <= pend_poll;
            e_last  <= 1'b1;
          end else begin
            served[sess] <= 1'b1;
            m            <= marks[sess];
            mask         <= '0;
            poll         <= 1'b0;
            tcnt         <= '0;
            // a further due session: the previous request goes out first
            if (pend_v) begin
              e_valid   <= 1'b1;
              e_sess    <= pend_sess;
              e_mask    <= pend_mask;
              e_poll    <= pend_poll;
              e_last    <= 1'b0;
              pend_v    <= 1'b0;
              pend_sess <= '0;
              pend_mask <= '0;
              pend_poll <= 1'b0;
            end
          end
        end
        ST_SV_RD: begin
          if (tdone) begin
            marks[sess] <= m;
            idx         <= '0;
          end else if (!m_bit) begin
            tcnt <= tcnt + TID_W'(1);
          end
        end
        ST_SV_CHK: begin
          if (alu_out.sleeping) begin
            tcnt <= tcnt + TID_W'(1);
          end else begin
            mask[tcnt] <= 1'b1;
            if (tcnt == TMR_IDLE) begin
              if (!m[TMR_ACK]) begin
                poll <= 1'b1;
              end
            end else if (!reload) begin
              m[tcnt] <= 1'b0;
              tcnt    <= tcnt + TID_W'(1);
            end
          end
        end
        ST_SV_UPD: tcnt <= tcnt + TID_W'(1);
        ST_EA_RD: begin
          if (tdone) begin
            key <= cur;
            idx <= '0;
          end else if (!m[st]) begin
            tcnt <= tcnt + TID_W'(1);
          end
        end
        ST_EA_CHK: begin
          if (first || alu_out.earlier) begin
            cur   <= dl_rdata;
            first <= 1'b0;
          end
          tcnt <= tcnt + TID_W'(1);
        end
        ST_WK_USE: wake <= (qcount != '0) ? ed_rdata : alu_out.res;
        ST_EMIT: begin
          if (!res.valid || res.ready) begin
            res.valid         <= 1'b1;
            res.session_valid <= e_valid;
            res.out_session   <= SESSION_W'(e_sess);
            res.expired_mask  <= e_mask;
            res.poll_cycle    <= e_poll;
            res.next_wakeup   <= wake;
            res.last          <= e_last;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/mstm_chk.sv
// Port-level checker for the session timer manager, bound to the top level
`timescale 1ns / 1ps
`include "multi_session_timer_manager_defines.svh"

module mstm_chk import mstm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic                  session_valid,
  input logic [SESSION_W-1:0]  out_session,
  input logic [NUM_TIMERS-1:0] expired_mask,
  input logic                  poll_cycle,
  input logic [TW-1:0]         next_wakeup,
  input logic                  last
);

  `MSTM_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")
  `MSTM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(next_wakeup) && $stable(last) && $stable(expired_mask), "stalled request changed")
  `MSTM_ASSERT_NOW(a_null_result, res_valid && !session_valid, out_session == '0 && expired_mask == '0 && !poll_cycle, "empty request carries data")
  `MSTM_ASSERT_NOW(a_poll_from_idle, res_valid && poll_cycle, session_valid && expired_mask[TMR_IDLE], "poll without idle expiry")

endmodule

bind multi_session_timer_manager mstm_chk u_mstm_chk (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .session_valid (res.session_valid),
  .out_session   (res.out_session),
  .expired_mask  (res.expired_mask),
  .poll_cycle    (res.poll_cycle),
  .next_wakeup   (res.next_wakeup),
  .last          (res.last)
);

FILE: bench/tb.sv
// Self-checking bench for the session timer manager: random and directed commands
`timescale 1ns / 1ps

module tb;
  import mstm_pkg::*;

  typedef struct packed {
    logic                  session_valid;
    logic [SESSION_W-1:0]  out_session;
    logic [NUM_TIMERS-1:0] expired_mask;
    logic                  poll_cycle;
    logic [TW-1:0]         next_wakeup;
    logic                  last;
  } outcome_t;

  localparam int rebuild_order [NUM_TIMERS] = '{8, 0, 1, 7, 3, 4, 2, 9, 5, 6};

  // software copy of the timer queue; works out the outcomes of each request
  class timer_scoreboard;
    logic [TW-1:0]         dl [16][NUM_TIMERS];
    logic [NUM_TIMERS-1:0] marks [16];
    logic [TW-1:0]         earliest [16];
    int                    order [$];
    logic [RW-1:0]         idle_per, retry_per, empty_per;
    outcome_t              pending [$];
    int                    errors, results, serviced;

    function new();
      for (int s = 0; s < 16; s++) marks[s] = '0;
      idle_per = '0; retry_per = '0; empty_per = EMPTY_WAKE_RESET;
      errors = 0; results = 0; serviced = 0;
    endfunction

    function bit earlier(logic [TW-1:0] a, logic [TW-1:0] b);
      logic [TW-1:0] d;
      d = a - b;
      return d[TW-1];
    endfunction

    function bit asleep(logic [TW-1:0] t, logic [TW-1:0] now);
      logic [TW-1:0] d;
      d = t - now;
      return d != 0 && !d[TW-1];
    endfunction

    function void dequeue(int s);
      foreach (order[i]) if (order[i] == s) begin
        order.delete(i);
        return;
      end
    endfunction

    function void enqueue(int s);
      int p;
      p = 0;
      while (p < order.size() && !earlier(earliest[s], earliest[order[p]])) p++;
      order.insert(p, s);
    endfunction

    function logic [TW-1:0] wake(logic [TW-1:0] now);
      if (order.size() > 0) return earliest[order[0]];
      return now + TW'(empty_per);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [RW-1:0] v);
      case (idx)
        REG_IDLE:  idle_per = v;
        REG_RETRY: retry_per = v;
        REG_EMPTY: empty_per = v;
        default: ;
      endcase
    endfunction

    function void note_request(cmd_t c, int s, int id, logic [RW-1:0] delta,
                               logic [TW-1:0] now);
      outcome_t o;
      bit served [16];
      logic [NUM_TIMERS-1:0] m, mask;
      logic [TW-1:0] t;
      int cand, n, tid;
      bit found, poll, first;
      o = '0;
      if (c == CMD_TICK) begin
        n = 0;
        foreach (served[i]) served[i] = 0;
        forever begin
          found = 0;
          foreach (order[i]) if (!served[order[i]]) begin
            cand = order[i]; found = 1; break;
          end
          if (!found || asleep(earliest[cand], now)) break;
          served[cand] = 1;
          m = marks[cand]; mask = '0; poll = 0;
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!m[i] || asleep(dl[cand][i], now)) continue;
            mask[i] = 1;
            if (i == TMR_IDLE) begin
              dl[cand][i] = now + TW'(idle_per);
              if (!m[TMR_ACK]) poll = 1;
            end else if (i == TMR_RETRY && retry_per != 0)
              dl[cand][i] = now + TW'(retry_per);
            else m[i] = 0;
          end
          marks[cand] = m;
          dequeue(cand);
          if (m != 0) begin
            first = 1;
            // rebuild visits retry first, then ack, timer 1, idle and the rest
            foreach (rebuild_order[k]) begin
              tid = rebuild_order[k];
              if (m[tid] && (first || earlier(dl[cand][tid], earliest[cand]))) begin
                first = 0;
                earliest[cand] = dl[cand][tid];
              end
            end
            enqueue(cand);
          end
          o = '{1'b1, SESSION_W'(cand), mask, poll, wake(now), 1'b0};
          pending.push_back(o);
          n++; serviced++;
        end
        if (n == 0) begin
          o = '{1'b0, '0, '0, 1'b0, wake(now), 1'b1};
          pending.push_back(o);
        end else pending[$].last = 1'b1;
        return;
      end
      if (id < NUM_TIMERS) begin
        if (c == CMD_START) begin
          t = now + TW'(delta);
          dequeue(s);
          if (marks[s] == 0 || earlier(t, earliest[s])) earliest[s] = t;
          marks[s][id] = 1;
          dl[s][id] = t;
          enqueue(s);
        end else if (c == CMD_STOP) marks[s][id] = 0;
      end
      o = '{1'b0, '0, '0, 1'b0, wake(now), 1'b1};
      pending.push_back(o);
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.session_valid !== want.session_valid || got.out_session !== want.out_session
          || got.expired_mask !== want.expired_mask || got.poll_cycle !== want.poll_cycle
          || got.next_wakeup !== want.next_wakeup || got.last !== want.last) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RW-1:0] cfg_data = '0;
  int send_idle = 0, recv_stall = 0;
  logic [TW-1:0] clock_now = 32'h0000_1000;
  bit sent_all = 0;
  timer_scoreboard sb;

  mstm_cmd_if cmd_ch();
  mstm_res_if res_ch();

  multi_session_timer_manager dut (.clk(clk), .rst(rst), .cmd(cmd_ch.sink),
    .res(res_ch.source), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

  always #5 clk = ~clk;

  initial begin
    cmd_ch.valid = 0; cmd_ch.command = CMD_TICK; cmd_ch.session = '0;
    cmd_ch.timer_id = '0; cmd_ch.delta_ticks = '0; cmd_ch.now_time = '0;
    res_ch.ready = 0;
  end

  // receiver side with random stalls
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result('{res_ch.session_valid, res_ch.out_session, res_ch.expired_mask,
                        res_ch.poll_cycle, res_ch.next_wakeup, res_ch.last});
    res_ch.ready <= !rst && ($urandom_range(99) >= recv_stall);
  end

  // the block stays busy after a request until its last result is registered, so the gap costs nothing
  task automatic send_request(cmd_t c, int s, int id, logic [RW-1:0] delta,
                              logic [TW-1:0] now);
    while ($urandom_range(99) < send_idle) @(posedge clk);
    cmd_ch.valid <= 1; cmd_ch.command <= c; cmd_ch.session <= s[SESSION_W-1:0];
    cmd_ch.timer_id <= id[TID_W-1:0]; cmd_ch.delta_ticks <= delta;
    cmd_ch.now_time <= now;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sb.note_request(c, s, id, delta, now);
    cmd_ch.valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [RW-1:0] v);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  // small deltas keep timers expiring; now moves forward a little each request
  task automatic random_request();
      int r;
      logic [RW-1:0] d;
      r = $urandom_range(99);
      clock_now = clock_now + $urandom_range(40);
      d = ($urandom_range(9) == 0) ? RW'($urandom) : RW'($urandom_range(120));
      if (r < 45) send_request(CMD_START, $urandom_range(15), $urandom_range(9), d, clock_now);
      else if (r < 80) send_request(CMD_TICK, $urandom_range(15), $urandom_range(15),
                                    RW'($urandom), clock_now);
      else if (r < 93) send_request(CMD_STOP, $urandom_range(15), $urandom_range(9), d,
                                    clock_now);
      else send_request($urandom_range(1) ? CMD_NONE : CMD_START, $urandom_range(15),
                        $urandom_range(15, 10), d, clock_now);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: reset defaults, extremes, idle/poll and retry rules, wraparound
    send_request(CMD_TICK, 0, 0, '0, 32'hFFFF_FFFF);
    send_request(CMD_START, 15, 9, RW'(0), 32'h0);
    send_request(CMD_START, 0, 0, {RW{1'b1}}, 32'hFFFF_FFF0);
    send_request(CMD_START, 3, 7, RW'(5), 32'h10);
    send_request(CMD_START, 4, 8, RW'(5), 32'h10);
    send_request(CMD_START, 5, 7, RW'(5), 32'h10);
    send_request(CMD_START, 5, 0, RW'(100), 32'h10);
    send_request(CMD_STOP, 15, 9, '0, 32'h10);
    send_request(CMD_START, 16 - 1, 12, RW'(3), 32'h10);
    send_request(CMD_NONE, 2, 2, RW'(3), 32'h10);
    send_request(CMD_TICK, 0, 0, '0, 32'h20);
    send_request(CMD_TICK, 0, 0, '0, 32'h200);
    write_reg(REG_IDLE, {RW{1'b1}});
    write_reg(REG_RETRY, RW'(7));
    write_reg(REG_EMPTY, '0);
    for (int t = 0; t < NUM_TIMERS; t++) send_request(CMD_START, 6, t, RW'(t), 32'h300);
    send_request(CMD_TICK, 0, 0, '0, 32'h320);
    send_request(CMD_TICK, 0, 0, '0, 32'h8000_0330);
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 74; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 74; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      write_reg(REG_IDLE, ph[0] ? RW'($urandom_range(60)) : RW'(0));
      write_reg(REG_RETRY, ph == 2 ? {RW{1'b1}} : RW'($urandom_range(50)));
      write_reg(REG_EMPTY, ph == 3 ? {RW{1'b1}} : RW'($urandom));
      repeat (48) random_request();
    end
    sent_all = 1;
  end

  initial begin
    wait (sent_all);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d requests worth of results: %0d checked, %0d session services.",
             sb.results, sb.results, sb.serviced);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/mstm_pkg.sv
rtl/mstm_ifc.sv
rtl/mstm_ram.sv
rtl/mstm_alu.sv
rtl/multi_session_timer_manager.sv
rtl/mstm_chk.sv
bench/tb.sv
